[hw/rtl/mdgb_pkg.sv]
package mdgb_pkg;

  localparam int DEPTH_W    = 16;
  localparam int DIM_W      = 11;
  localparam int SUM_W      = 22;
  localparam int WSUM_W     = 7;
  localparam int WGT_W      = 4;
  localparam int TAPS       = 25;
  localparam int TAP_W      = 5;
  localparam int KSIZE      = 5;
  localparam int KCOL_W     = 3;
  localparam int CENTER_TAP = 12;
  localparam int DIV_STEPS  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVALID_DEPTH = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_READ,
    ST_WAIT,
    ST_CALC,
    ST_DIV,
    ST_FIN
  } blur_state_t;

  // one step of the restoring divider; quotient bits shift into dvd
  typedef struct packed {
    logic                valid;
    logic [WSUM_W-1:0]   rem;
    logic [DEPTH_W-1:0]  dvd;
    logic [WSUM_W-1:0]   div;
  } div_cell_t;

  function automatic logic [WGT_W-1:0] kernel_weight(input logic [TAP_W-1:0] tap);
    logic [WGT_W-1:0] w;
    case (tap)
      5'd6, 5'd8, 5'd16, 5'd18: w = 4'd3;
      5'd7, 5'd11, 5'd13, 5'd17: w = 4'd5;
      5'd12:                     w = 4'd10;
      default:                   w = 4'd1;
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/mdgb_div_cell.sv]
module mdgb_div_cell import mdgb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  div_cell_t prev,
  output div_cell_t cur
);

  logic [WSUM_W:0]    trial;
  logic               ge;
  logic [WSUM_W-1:0]  rem_next;
  logic [DEPTH_W-1:0] dvd_next;

  always_comb begin
    trial    = {prev.rem, prev.dvd[DEPTH_W-1]};
    ge       = trial >= {1'b0, prev.div};
    rem_next = ge ? WSUM_W'(trial - {1'b0, prev.div}) : WSUM_W'(trial);
    dvd_next = {prev.dvd[DEPTH_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else begin
      cur.valid <= prev.valid;
    end
    cur.rem <= rem_next;
    cur.dvd <= dvd_next;
    cur.div <= prev.div;
  end

endmodule

[hw/rtl/mdgb_hist_mem.sv]
module mdgb_hist_mem import mdgb_pkg::*; #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [DEPTH_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic [DEPTH_W-1:0] rd_data
);

  logic [DEPTH_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/masked_depth_gaussian_blur_top.sv]
// channel   dir  fields (low bit up)              handshake
// s_*       in   tdata: depth[15:0]; tuser: cmd    tvalid/tready
// m_*       out  tdata: depth_out[15:0]; tuser:    tvalid/tready
//                frame_done
// cfg_*     in   index, data                       cfg_we, no wait
// a pixel request that yields no result leaves the block idle and ready for the next
// a border or flush result needs one history read
// an interior result needs 25 serial history reads on the single read port, then
// passes through the divider cell chain, which it skips with an invalid center
// history memory is not cleared after reset; rst clears control state
// a finished result waits in the output register while the next request is taken
module masked_depth_gaussian_blur_top import mdgb_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [DEPTH_W-1:0]    s_tdata,   // depth
  input  logic [0:0]            s_tuser,   // cmd
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [DEPTH_W-1:0]    m_tdata,   // depth_out
  output logic [0:0]            m_tuser,   // frame_done
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int HIST = 8 * MAX_WIDTH;
  localparam int AB   = $clog2(HIST);
  localparam int WB   = $clog2(MAX_WIDTH + 1);
  localparam int HB   = $clog2(MAX_HEIGHT + 1);
  localparam int DB   = $clog2(2 * MAX_WIDTH + 3);
  localparam int XB   = $clog2(4 * MAX_WIDTH + 5);

  logic [DIM_W-1:0]   frame_width, frame_height;
  logic [DEPTH_W-1:0] invalid_depth;

  blur_state_t state, state_next;

  logic [AB-1:0]      wr_ptr, rd_addr;
  logic [WB-1:0]      col_pos;
  logic [HB-1:0]      row_pos;
  logic [DB-1:0]      drain_left;
  logic               flushing, interior, done_flag;
  logic [XB-1:0]      tap_dist;
  logic [TAP_W-1:0]   tap, rd_tap;
  logic [KCOL_W-1:0]  kcol;
  logic               rd_v;
  logic [SUM_W-1:0]   sum;
  logic [WSUM_W-1:0]  wsum;
  logic [DEPTH_W-1:0] center, result, rd_data;

  logic [WB-1:0]      w_eff;
  logic [HB-1:0]      h_eff;
  logic [DB-1:0]      lag, drain_clamp, drain_eff;
  logic [WB-1:0]      pos_col, adv_col;
  logic [HB-1:0]      pos_row, adv_row;
  logic               pos_interior, pos_end;
  logic               req, req_flush, req_pixel, rd_en, out_load, div_launch, use_div;
  logic [AB:0]        start_t, step_t, step_inc;
  logic [AB-1:0]      start_addr, step_addr;

  div_cell_t stage [DIV_STEPS+1];

  // effective frame size
  always_comb begin
    if (frame_width == '0) w_eff = WB'(1);
    else if (32'(frame_width) > MAX_WIDTH) w_eff = WB'(MAX_WIDTH);
    else w_eff = WB'(frame_width);
    if (frame_height == '0) h_eff = HB'(1);
    else if (32'(frame_height) > MAX_HEIGHT) h_eff = HB'(MAX_HEIGHT);
    else h_eff = HB'(frame_height);
    lag = DB'({w_eff, 1'b0}) + DB'(2);
  end

  assign req       = s_tvalid && s_tready;
  assign req_flush = req && (s_tuser[0] == CMD_FLUSH);
  assign req_pixel = req && (s_tuser[0] == CMD_PIXEL);

  // position of the result that a request would produce
  always_comb begin
    drain_clamp = (drain_left > lag) ? lag : drain_left;
    drain_eff   = flushing ? '0 : drain_left;
    if (s_tuser[0] == CMD_FLUSH) begin
      pos_col = col_pos;
      pos_row = row_pos;
    end else begin
      pos_col = flushing ? '0 : col_pos;
      pos_row = flushing ? '0 : row_pos;
    end
    pos_interior = (pos_row >= HB'(2)) && (({1'b0, pos_row} + (HB+1)'(2)) < {1'b0, h_eff})
                && (pos_col >= WB'(2)) && (({1'b0, pos_col} + (WB+1)'(2)) < {1'b0, w_eff});
    pos_end = (({1'b0, pos_row} + (HB+1)'(1)) == {1'b0, h_eff})
           && (({1'b0, pos_col} + (WB+1)'(1)) == {1'b0, w_eff});
    if (({1'b0, pos_col} + (WB+1)'(1)) >= {1'b0, w_eff}) begin
      adv_col = '0;
      adv_row = (({1'b0, pos_row} + (HB+1)'(1)) >= {1'b0, h_eff}) ? '0 : pos_row + HB'(1);
    end else begin
      adv_col = pos_col + WB'(1);
      adv_row = pos_row;
    end
  end

  // history addresses, modulo the memory depth
  always_comb begin
    start_t    = {1'b0, wr_ptr} + (AB+1)'(HIST - 1) - (AB+1)'(tap_dist);
    start_addr = (start_t >= (AB+1)'(HIST)) ? AB'(start_t - (AB+1)'(HIST)) : AB'(start_t);
    step_inc   = (kcol == KCOL_W'(KSIZE - 1)) ? ((AB+1)'(w_eff) - (AB+1)'(4)) : (AB+1)'(1);
    step_t     = {1'b0, rd_addr} + step_inc;
    step_addr  = (step_t >= (AB+1)'(HIST)) ? AB'(step_t - (AB+1)'(HIST)) : AB'(step_t);
  end

  assign use_div = interior && (center != invalid_depth);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_flush && drain_left != '0) state_next = ST_ADDR;
        else if (req_pixel && drain_eff >= lag) state_next = ST_ADDR;
      end
      ST_ADDR: state_next = ST_READ;
      ST_READ: begin
        if (!interior || tap == TAP_W'(TAPS - 1)) state_next = ST_WAIT;
      end
      ST_WAIT: state_next = ST_CALC;
      ST_CALC: state_next = use_div ? ST_DIV : ST_FIN;
      ST_DIV: begin
        if (stage[DIV_STEPS].valid) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready   = 1'b0;
    rd_en      = 1'b0;
    div_launch = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_READ: rd_en = 1'b1;
      ST_CALC: div_launch = use_div;
      ST_FIN:  out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      frame_width   <= DIM_W'(640);
      frame_height  <= DIM_W'(480);
      invalid_depth <= '1;
      wr_ptr        <= '0;
      col_pos       <= '0;
      row_pos       <= '0;
      drain_left    <= '0;
      flushing      <= 1'b0;
      rd_v          <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      rd_v  <= rd_en;
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH:   frame_width   <= cfg_data[DIM_W-1:0];
          REG_FRAME_HEIGHT:  frame_height  <= cfg_data[DIM_W-1:0];
          REG_INVALID_DEPTH: invalid_depth <= cfg_data;
          default: ;
        endcase
      end
      if (req_flush && drain_left != '0) begin
        flushing   <= 1'b1;
        drain_left <= drain_clamp - DB'(1);
        col_pos    <= adv_col;
        row_pos    <= adv_row;
      end else if (req_pixel) begin
        flushing <= 1'b0;
        wr_ptr   <= (wr_ptr == AB'(HIST - 1)) ? '0 : wr_ptr + AB'(1);
        if (drain_eff < lag) begin
          drain_left <= drain_eff + DB'(1);
          col_pos    <= pos_col;
          row_pos    <= pos_row;
        end else begin
          drain_left <= lag;
          col_pos    <= adv_col;
          row_pos    <= adv_row;
        end
      end
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_flush) begin
      interior  <= 1'b0;
      done_flag <= pos_end;
      tap_dist  <= XB'(drain_clamp - DB'(1));
    end else if (req_pixel) begin
      interior  <= pos_interior;
      done_flag <= pos_end;
      tap_dist  <= pos_interior ? XB'(lag) + XB'({w_eff, 1'b0}) + XB'(2) : XB'(lag);
    end
    if (state == ST_ADDR) begin
      rd_addr <= start_addr;
      tap     <= '0;
      kcol    <= '0;
      sum     <= '0;
      wsum    <= '0;
    end else if (rd_en) begin
      rd_addr <= step_addr;
      tap     <= tap + TAP_W'(1);
      kcol    <= (kcol == KCOL_W'(KSIZE - 1)) ? '0 : kcol + KCOL_W'(1);
    end
    rd_tap <= tap;
    if (rd_v) begin
      if (rd_data != invalid_depth) begin
        sum  <= sum + SUM_W'(rd_data) * SUM_W'(kernel_weight(rd_tap));
        wsum <= wsum + WSUM_W'(kernel_weight(rd_tap));
      end
      if (!interior || rd_tap == TAP_W'(CENTER_TAP)) center <= rd_data;
    end
    if (state == ST_CALC && !use_div) result <= center;
    if (state == ST_DIV && stage[DIV_STEPS].valid) result <= stage[DIV_STEPS].dvd;
    if (out_load) begin
      m_tdata <= result;
      m_tuser <= done_flag;
    end
  end

  mdgb_hist_mem #(
    .DEPTH (HIST),
    .AW    (AB)
  ) u_hist (
    .clk     (clk),
    .wr_en   (req_pixel),
    .wr_addr (wr_ptr),
    .wr_data (s_tdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    stage[0].valid = div_launch;
    stage[0].rem   = WSUM_W'(sum[SUM_W-1:DEPTH_W]);
    stage[0].dvd   = sum[DEPTH_W-1:0];
    stage[0].div   = wsum;
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    mdgb_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .prev (stage[i]),
      .cur  (stage[i+1])
    );
  end

endmodule

[hw/rtl/mdgb_checker.sv]
module mdgb_checker import mdgb_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [DEPTH_W-1:0]    s_tdata,
  input logic [0:0]            s_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [DEPTH_W-1:0]    m_tdata,
  input logic [0:0]            m_tuser
);

  // no result appears right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // a request never produces a result too soon after it
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !$rose(m_tvalid) ##1 !$rose(m_tvalid))
    else $error("result too soon after request");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(m_tvalid) |-> ($past(m_tready) || $past(rst)))
    else $error("result dropped without handshake");

  // a waiting request is held by the sender
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && !s_tready) |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
    else $error("waiting request changed");

endmodule

bind masked_depth_gaussian_blur_top mdgb_checker u_chk (.*);

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import mdgb_pkg::*;

  localparam int HIST_N = 8 * 1024;
  localparam int LIMIT  = 3000000;

  typedef struct {
    logic              cmd;
    logic [DEPTH_W-1:0] depth;
  } pix_req_t;

  typedef struct {
    logic [DEPTH_W-1:0] depth;
    logic               done;
  } blur_res_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [DEPTH_W-1:0]    s_tdata = '0;
  logic [0:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [DEPTH_W-1:0]    m_tdata;
  logic [0:0]            m_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  masked_depth_gaussian_blur_top DUT (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // mirror of the filter state
  logic [DEPTH_W-1:0] hist [HIST_N];
  int unsigned wr_ptr, col_pos, row_pos, pending;
  bit          flushing;
  int unsigned width_reg = 640, height_reg = 480;
  logic [DEPTH_W-1:0] invalid_reg = 16'hFFFF;

  pix_req_t  req_q[$];
  blur_res_t blur_q[$];
  int        failures = 0;
  int        cycles = 0;
  bit        steady = 0;
  int        hold_left = 0;
  bit        held = 0;

  function automatic logic [DEPTH_W-1:0] hist_back(int unsigned d);
    return hist[(wr_ptr + HIST_N - 1 - (d % HIST_N)) % HIST_N];
  endfunction

  function automatic int unsigned wgt(int r, int c);
    if (r == 0 || r == 4 || c == 0 || c == 4) return 1;
    if (r == 2 && c == 2) return 10;
    if (r == 2 || c == 2) return 5;
    return 3;
  endfunction

  function automatic logic [DEPTH_W-1:0] blur_at(int unsigned back_dist, int unsigned w);
    logic [DEPTH_W-1:0] ctr, v;
    int unsigned sum, wsum;
    ctr = hist_back(back_dist);
    sum = 0;
    wsum = 0;
    if (ctr == invalid_reg) return ctr;
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 5; c++) begin
        v = hist_back(back_dist + (2 - r) * w + (2 - c));
        if (v != invalid_reg) begin
          sum += v * wgt(r, c);
          wsum += wgt(r, c);
        end
      end
    end
    return DEPTH_W'(sum / wsum);
  endfunction

  function automatic void push_result(logic [DEPTH_W-1:0] v, int unsigned w, int unsigned h);
    blur_res_t res;
    res.depth = v;
    res.done = (row_pos == h - 1 && col_pos == w - 1);
    blur_q.push_back(res);
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endfunction

  function automatic void predict_blur(pix_req_t rq);
    int unsigned w, h, lag;
    logic [DEPTH_W-1:0] v;
    w = (width_reg == 0) ? 1 : (width_reg > 1024) ? 1024 : width_reg;
    h = (height_reg == 0) ? 1 : (height_reg > 1024) ? 1024 : height_reg;
    lag = 2 * w + 2;
    if (rq.cmd == CMD_FLUSH) begin
      if (pending == 0) return;
      if (pending > lag) pending = lag;
      flushing = 1;
      v = hist_back(pending - 1);
      pending--;
      push_result(v, w, h);
      return;
    end
    if (flushing) begin
      flushing = 0;
      pending = 0;
      col_pos = 0;
      row_pos = 0;
    end
    hist[wr_ptr] = rq.depth;
    wr_ptr = (wr_ptr + 1) % HIST_N;
    if (pending < lag) begin
      pending++;
      return;
    end
    if (row_pos >= 2 && row_pos + 2 < h && col_pos >= 2 && col_pos + 2 < w)
      v = blur_at(lag, w);
    else
      v = hist_back(lag);
    push_result(v, w, h);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(99);
    if (steady || p < 65) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // sender
  int unsigned src_gap = 0;
  always @(posedge clk) begin
    pix_req_t rq;
    logic     nv;
    cycles <= cycles + 1;
    if (cycles % 700 == 0) steady <= ~steady;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      nv = s_tvalid;
      if (s_tvalid && s_tready) begin
        predict_blur('{s_tuser[0], s_tdata});
        nv = 1'b0;
        src_gap = pick_gap();
      end
      if (!nv) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (req_q.size() > 0) begin
          rq = req_q.pop_front();
          s_tuser <= rq.cmd;
          s_tdata <= rq.depth;
          nv = 1'b1;
        end
      end
      s_tvalid <= nv;
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    blur_res_t ex;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (blur_q.size() == 0) begin
          $error("unexpected result depth_out=%0d frame_done=%0d", m_tdata, m_tuser);
          failures++;
        end else begin
          ex = blur_q.pop_front();
          if (m_tdata !== ex.depth) begin
            $error("depth_out: expected %0d, got %0d", ex.depth, m_tdata);
            failures++;
          end
          if (m_tuser[0] !== ex.done) begin
            $error("frame_done: expected %0d, got %0d", ex.done, m_tuser[0]);
            failures++;
          end
        end
      end
      // long hold once a result is waiting, so the block backs up
      if (!held && cycles >= 6000 && m_tvalid) begin
        held = 1;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= (pick_gap() == 0);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("masked_depth_gaussian_blur_top test failed");
      $finish;
    end
  end

  task automatic settle();
    wait (req_q.size() == 0 && !s_tvalid && blur_q.size() == 0);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:   width_reg = val & 16'h07FF;
      REG_FRAME_HEIGHT:  height_reg = val & 16'h07FF;
      REG_INVALID_DEPTH: invalid_reg = val;
      default: ;
    endcase
  endtask

  function automatic logic [DEPTH_W-1:0] rand_depth();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 20) return invalid_reg;
    if (p < 25) return 16'hFFFF;
    if (p < 30) return 16'h0000;
    if (p < 60) return DEPTH_W'(16'd1000 + $urandom_range(255));
    return DEPTH_W'($urandom_range(16'hFFFF));
  endfunction

  task automatic send(logic cmd, logic [DEPTH_W-1:0] d);
    req_q.push_back('{cmd, d});
  endtask

  // pixels with occasional flush bursts, then a full drain plus one empty flush
  task automatic run_phase(int unsigned w, int unsigned h, logic [DEPTH_W-1:0] inv,
                           int n, int flush_pct);
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_INVALID_DEPTH, inv);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < flush_pct)
        repeat ($urandom_range(4, 1)) send(CMD_FLUSH, DEPTH_W'($urandom_range(16'hFFFF)));
      send(CMD_PIXEL, rand_depth());
    end
    settle();
    repeat (pending + 1) send(CMD_FLUSH, DEPTH_W'($urandom_range(16'hFFFF)));
    settle();
  endtask

  initial begin
    logic [DEPTH_W-1:0] edge_vals [8] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                                          16'h7FFF, 16'hFFFE, 16'h5555, 16'hAAAA};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (5) @(posedge clk);

    // directed: empty flush, extreme samples, invalid marker, partial flush
    write_reg(REG_FRAME_WIDTH, 8);
    write_reg(REG_FRAME_HEIGHT, 6);
    write_reg(REG_INVALID_DEPTH, 16'hFFFF);
    send(CMD_FLUSH, 16'h1234);
    for (int i = 0; i < 22; i++) send(CMD_PIXEL, edge_vals[i % 8]);
    send(CMD_FLUSH, 16'h0);
    send(CMD_FLUSH, 16'hFFFF);
    send(CMD_PIXEL, 16'h00FF);
    settle();

    run_phase(8, 6, 16'hFFFF, 100, 0);
    run_phase(0, 0, 16'h0000, 40, 5);
    run_phase(5, 5, DEPTH_W'($urandom_range(16'hFFFF)), 150, 0);
    run_phase(2047, 2047, 16'hFFFF, 60, 0);
    run_phase(12, 9, 16'h0000, 300, 2);
    run_phase(7, 1024, 16'hFFFF, 200, 1);
    run_phase(1024, 3, 16'h0400, 150, 0);
    run_phase(6, 7, 16'hFFFF, 120, 3);

    if (failures == 0)
      $display("masked_depth_gaussian_blur_top test passed");
    else
      $display("masked_depth_gaussian_blur_top test failed");
    $finish;
  end

endmodule
